>>> hdl/mbpwm_pkg.sv
package mbpwm_pkg;

  localparam int CHANNELS = 16;
  localparam int PERIOD   = 100;

  localparam int CH_W    = 4;
  localparam int NUM_W   = 8;
  localparam int DUTY_W  = 8;
  localparam int PIN_W   = 16;
  localparam int PIN_AW  = $clog2(PIN_W);
  localparam int CH_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DIV_W   = 2 * NUM_W;
  localparam int DIV_CW  = $clog2(DIV_W);

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [NUM_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] duty;
  } div_rsp_t;

endpackage

>>> hdl/mbpwm_if.sv
interface mbpwm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        opcode;
  logic [mbpwm_pkg::CH_W-1:0]  channel;
  logic [mbpwm_pkg::NUM_W-1:0] numerator;
  logic [mbpwm_pkg::NUM_W-1:0] denominator;

  modport source (output valid, opcode, channel, numerator, denominator, input ready);
  modport sink   (input valid, opcode, channel, numerator, denominator, output ready);
endinterface

interface mbpwm_out_if;
  logic                        valid;
  logic                        ready;
  logic [mbpwm_pkg::PIN_W-1:0] pin_levels;
  logic                        period_end;

  modport source (output valid, pin_levels, period_end, input ready);
  modport sink   (input valid, pin_levels, period_end, output ready);
endinterface

>>> hdl/mbpwm_ram.sv
module mbpwm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/mbpwm_div.sv
// restoring divider, one quotient bit per cycle, saturates at PERIOD
module mbpwm_div (
  input  logic                clk,
  input  logic                rst_n,
  input  mbpwm_pkg::div_req_t req,
  output mbpwm_pkg::div_rsp_t rsp
);

  logic                           busy_r, busy_nxt;
  logic                           fin_r, fin_nxt;
  logic [mbpwm_pkg::DIV_CW-1:0]   cnt_r, cnt_nxt;
  logic [mbpwm_pkg::NUM_W-1:0]    rem_r, rem_nxt;
  logic [mbpwm_pkg::DIV_W-1:0]    quo_r, quo_nxt;
  logic [mbpwm_pkg::NUM_W-1:0]    den_r, den_nxt;
  logic [mbpwm_pkg::NUM_W:0]      part;
  logic [mbpwm_pkg::NUM_W:0]      diff;
  logic                           ge;

  always_comb begin
    part     = {rem_r, quo_r[mbpwm_pkg::DIV_W-1]};
    ge       = (part >= {1'b0, den_r});
    diff     = part - {1'b0, den_r};
    busy_nxt = busy_r;
    fin_nxt  = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      den_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[mbpwm_pkg::NUM_W-1:0] : part[mbpwm_pkg::NUM_W-1:0];
      quo_nxt = {quo_r[mbpwm_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == mbpwm_pkg::DIV_CW'(mbpwm_pkg::DIV_W - 1)) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  // zero divisor yields all-ones quotient and saturates here too
  assign rsp.done = fin_r;
  assign rsp.duty = (quo_r > mbpwm_pkg::DIV_W'(mbpwm_pkg::PERIOD)) ?
                    mbpwm_pkg::DUTY_W'(mbpwm_pkg::PERIOD) : quo_r[mbpwm_pkg::DUTY_W-1:0];

endmodule

>>> hdl/multichannel_buffered_pwm_unit.sv
// channel | dir | handshake       | payload
// in_ch   | in  | valid/ready     | opcode, channel, numerator, denominator
// out_ch  | out | valid/ready     | pin_levels, period_end
//
// Set-duty request: the divider is started and runs its 16-step restoring
// division, then one write to the shadow duty RAM. Tick request: one read of
// the active and shadow duty RAMs per channel. Reset clears the valid bits at
// once, no clearing pass. A finished tick waits while the output register is
// full; a new request is taken once the result has moved into it.
module multichannel_buffered_pwm_unit (
  input  logic        clk,
  input  logic        rst_n,
  mbpwm_in_if.sink    in_ch,
  mbpwm_out_if.source out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_TICK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam logic [mbpwm_pkg::CH_AW-1:0] CH_LAST =
    mbpwm_pkg::CH_AW'(mbpwm_pkg::CHANNELS - 1);

  state_t                          state_r, state_nxt;
  logic [mbpwm_pkg::DUTY_W-1:0]    cnt_r, cnt_nxt;
  logic                            wrap_r, wrap_nxt;
  logic [mbpwm_pkg::CH_AW-1:0]     issue_idx_r, issue_idx_nxt;
  logic                            issue_on_r, issue_on_nxt;
  logic                            rd_vld_r, rd_vld_nxt;
  logic [mbpwm_pkg::CH_AW-1:0]     rd_idx_r, rd_idx_nxt;
  logic [mbpwm_pkg::PIN_W-1:0]     levels_r, levels_nxt;
  logic [mbpwm_pkg::CH_AW-1:0]     ch_r, ch_nxt;
  logic [mbpwm_pkg::CHANNELS-1:0]  act_vld_r, act_vld_nxt;
  logic [mbpwm_pkg::CHANNELS-1:0]  sh_vld_r, sh_vld_nxt;
  logic                            out_vld_r, out_vld_nxt;
  logic [mbpwm_pkg::PIN_W-1:0]     out_lvl_r, out_lvl_nxt;
  logic                            out_end_r, out_end_nxt;

  mbpwm_pkg::div_req_t             div_req;
  mbpwm_pkg::div_rsp_t             div_rsp;

  logic                            rd_en;
  logic                            act_we, sh_we;
  logic [mbpwm_pkg::DUTY_W-1:0]    act_wdata, act_q, sh_q;
  logic [mbpwm_pkg::DUTY_W-1:0]    act_val;
  logic [7:0]                      idx8;

  mbpwm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  mbpwm_ram #(.WIDTH(mbpwm_pkg::DUTY_W), .DEPTH(mbpwm_pkg::CHANNELS)) u_act_ram (
    .clk   (clk),
    .we    (act_we),
    .waddr (rd_idx_r),
    .wdata (act_wdata),
    .re    (rd_en),
    .raddr (issue_idx_r),
    .rdata (act_q)
  );

  mbpwm_ram #(.WIDTH(mbpwm_pkg::DUTY_W), .DEPTH(mbpwm_pkg::CHANNELS)) u_sh_ram (
    .clk   (clk),
    .we    (sh_we),
    .waddr (ch_r),
    .wdata (div_rsp.duty),
    .re    (rd_en),
    .raddr (issue_idx_r),
    .rdata (sh_q)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_vld_r;
  assign out_ch.pin_levels = out_lvl_r;
  assign out_ch.period_end = out_end_r;

  assign rd_en = (state_r == S_TICK) && issue_on_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    wrap_nxt      = wrap_r;
    issue_idx_nxt = issue_idx_r;
    issue_on_nxt  = issue_on_r;
    rd_vld_nxt    = rd_vld_r;
    rd_idx_nxt    = rd_idx_r;
    levels_nxt    = levels_r;
    ch_nxt        = ch_r;
    act_vld_nxt   = act_vld_r;
    sh_vld_nxt    = sh_vld_r;
    out_vld_nxt   = out_vld_r;
    out_lvl_nxt   = out_lvl_r;
    out_end_nxt   = out_end_r;

    div_req.start    = 1'b0;
    div_req.dividend = mbpwm_pkg::DIV_W'(in_ch.numerator) *
                       mbpwm_pkg::DIV_W'(mbpwm_pkg::PERIOD);
    div_req.divisor  = in_ch.denominator;

    act_we    = 1'b0;
    sh_we     = 1'b0;
    act_val   = act_vld_r[rd_idx_r] ? act_q : '0;
    act_wdata = sh_vld_r[rd_idx_r] ? sh_q : '0;
    idx8      = 8'(rd_idx_r);

    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.opcode == mbpwm_pkg::OP_TICK) begin
            state_nxt     = S_TICK;
            issue_idx_nxt = '0;
            issue_on_nxt  = 1'b1;
            rd_vld_nxt    = 1'b0;
            levels_nxt    = '0;
            wrap_nxt      = ({1'b0, cnt_r} + 9'd1) >= 9'(mbpwm_pkg::PERIOD);
          end else if (8'(in_ch.channel) < 8'(mbpwm_pkg::CHANNELS)) begin
            state_nxt     = S_DIV;
            div_req.start = 1'b1;
            ch_nxt        = mbpwm_pkg::CH_AW'(in_ch.channel);
          end
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          sh_we            = 1'b1;
          sh_vld_nxt[ch_r] = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_TICK: begin
        rd_vld_nxt = issue_on_r;
        rd_idx_nxt = issue_idx_r;
        if (issue_on_r) begin
          if (issue_idx_r == CH_LAST) begin
            issue_on_nxt = 1'b0;
          end else begin
            issue_idx_nxt = issue_idx_r + 1'b1;
          end
        end
        if (rd_vld_r) begin
          if ((act_val > cnt_r) && (idx8 < 8'(mbpwm_pkg::PIN_W))) begin
            levels_nxt[idx8[mbpwm_pkg::PIN_AW-1:0]] = 1'b1;
          end
          if (wrap_r) begin
            act_we                = 1'b1;
            act_vld_nxt[rd_idx_r] = 1'b1;
          end
          if (rd_idx_r == CH_LAST) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt = 1'b1;
          out_lvl_nxt = levels_r;
          out_end_nxt = wrap_r;
          cnt_nxt     = wrap_r ? '0 : cnt_r + 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      issue_on_r <= 1'b0;
      rd_vld_r   <= 1'b0;
      act_vld_r  <= '0;
      sh_vld_r   <= '0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      issue_on_r <= issue_on_nxt;
      rd_vld_r   <= rd_vld_nxt;
      act_vld_r  <= act_vld_nxt;
      sh_vld_r   <= sh_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wrap_r      <= wrap_nxt;
    issue_idx_r <= issue_idx_nxt;
    rd_idx_r    <= rd_idx_nxt;
    levels_r    <= levels_nxt;
    ch_r        <= ch_nxt;
    out_lvl_r   <= out_lvl_nxt;
    out_end_r   <= out_end_nxt;
  end

endmodule

>>> hdl/mbpwm_chk.sv
module mbpwm_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_opcode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [mbpwm_pkg::PIN_W-1:0] pin_levels,
  input logic                        period_end
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pin_levels) && $stable(period_end))
    else $error("result changed while stalled");

  // ready drops only on an accepted request
  a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_ready) |-> $past(in_valid))
    else $error("ready dropped without a request");

  // set-duty never produces a result
  a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode == mbpwm_pkg::OP_SET) |=> !$rose(out_valid))
    else $error("result after set-duty request");

  // a result is loaded only from a busy block
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

endmodule

bind multichannel_buffered_pwm_unit mbpwm_chk u_mbpwm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_opcode  (in_ch.opcode),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pin_levels (out_ch.pin_levels),
  .period_end (out_ch.period_end)
);

>>> dv/mbpwm_pwm_checker.sv
module mbpwm_pwm_checker (
  input  logic clk,
  input  logic rst_n,
  mbpwm_in_if  in_ch,
  mbpwm_out_if out_ch,
  output int   error_count,
  output int   ticks_in_flight
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [mbpwm_pkg::PIN_W-1:0] pin_levels;
    logic                        period_end;
  } tick_result_t;

  tick_result_t                 expected_ticks[$];
  logic [mbpwm_pkg::DUTY_W-1:0] period_count;
  logic [mbpwm_pkg::DUTY_W-1:0] active_duty [mbpwm_pkg::CHANNELS];
  logic [mbpwm_pkg::DUTY_W-1:0] shadow_duty [mbpwm_pkg::CHANNELS];

  function automatic logic [mbpwm_pkg::DUTY_W-1:0] fraction_to_duty(
      input logic [mbpwm_pkg::NUM_W-1:0] num,
      input logic [mbpwm_pkg::NUM_W-1:0] den);
    int quotient;
    if (den == '0) return mbpwm_pkg::DUTY_W'(mbpwm_pkg::PERIOD);
    quotient = (int'(num) * mbpwm_pkg::PERIOD) / int'(den);
    if (quotient > mbpwm_pkg::PERIOD) quotient = mbpwm_pkg::PERIOD;
    return mbpwm_pkg::DUTY_W'(quotient);
  endfunction

  // Compare against the current counter, then step it; wrap reloads the shadows.
  function automatic tick_result_t advance_tick();
    tick_result_t res;
    int next_count;
    res = '0;
    for (int i = 0; i < mbpwm_pkg::CHANNELS && i < mbpwm_pkg::PIN_W; i++) begin
      res.pin_levels[i] = (active_duty[i] > period_count);
    end
    next_count = int'(period_count) + 1;
    if (next_count >= mbpwm_pkg::PERIOD) begin
      next_count = 0;
      res.period_end = 1'b1;
      for (int i = 0; i < mbpwm_pkg::CHANNELS; i++) active_duty[i] = shadow_duty[i];
    end
    period_count = mbpwm_pkg::DUTY_W'(next_count);
    return res;
  endfunction

  always @(posedge clk) begin : watch
    tick_result_t seen;
    tick_result_t want;
    if (!rst_n) begin
      period_count = '0;
      for (int i = 0; i < mbpwm_pkg::CHANNELS; i++) begin
        active_duty[i] = '0;
        shadow_duty[i] = '0;
      end
      expected_ticks.delete();
      error_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        seen.pin_levels = out_ch.pin_levels;
        seen.period_end = out_ch.period_end;
        if (expected_ticks.size() == 0) begin
          error_count++;
          $display("%0t: result with no tick pending: expected none, got %h %b",
                   $time, seen.pin_levels, seen.period_end);
        end else begin
          want = expected_ticks.pop_front();
          if (seen.pin_levels !== want.pin_levels) begin
            error_count++;
            $display("%0t: pin_levels expected %h got %h",
                     $time, want.pin_levels, seen.pin_levels);
          end
          if (seen.period_end !== want.period_end) begin
            error_count++;
            $display("%0t: period_end expected %b got %b",
                     $time, want.period_end, seen.period_end);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (in_ch.opcode == mbpwm_pkg::OP_TICK) begin
          expected_ticks.push_back(advance_tick());
        end else if (int'(in_ch.channel) < mbpwm_pkg::CHANNELS) begin
          shadow_duty[in_ch.channel] = fraction_to_duty(in_ch.numerator,
                                                        in_ch.denominator);
        end
      end
    end
    ticks_in_flight = expected_ticks.size();
  end

endmodule

>>> dv/multichannel_buffered_pwm_unit_tb.sv
module multichannel_buffered_pwm_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REQUESTS = 750;
  localparam int SEGMENT_LEN     = 50;
  localparam int SETTLE_CYCLES   = 2 * (mbpwm_pkg::CHANNELS + 3) + 2;

  logic clk;
  logic rst_n;
  bit   steady;
  int   check_errors;
  int   ticks_pending;

  mbpwm_in_if  req_if ();
  mbpwm_out_if res_if ();

  multichannel_buffered_pwm_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  mbpwm_pwm_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (req_if),
    .out_ch          (res_if),
    .error_count     (check_errors),
    .ticks_in_flight (ticks_pending)
  );

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("multichannel_buffered_pwm_unit: mismatch");
    $finish;
  end

  // Mostly short gaps, a few long ones; none while steady.
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  task automatic send_request(input logic op, input logic [mbpwm_pkg::CH_W-1:0] ch,
                              input logic [mbpwm_pkg::NUM_W-1:0] num,
                              input logic [mbpwm_pkg::NUM_W-1:0] den);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid       = 1'b1;
    req_if.opcode      = op;
    req_if.channel     = ch;
    req_if.numerator   = num;
    req_if.denominator = den;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    req_if.valid = 1'b0;
    while (ticks_pending != 0) @(negedge clk);
  endtask

  task automatic send_random_duty();
    logic [mbpwm_pkg::NUM_W-1:0] num;
    logic [mbpwm_pkg::NUM_W-1:0] den;
    int pick;
    pick = $urandom_range(0, 99);
    den  = mbpwm_pkg::NUM_W'($urandom_range(0, 255));
    if (pick < 8) begin
      den = '0;
      num = mbpwm_pkg::NUM_W'($urandom_range(0, 255));
    end else if (pick < 70) begin
      num = mbpwm_pkg::NUM_W'($urandom_range(0, den));
    end else begin
      num = mbpwm_pkg::NUM_W'($urandom_range(0, 255));
    end
    send_request(mbpwm_pkg::OP_SET, mbpwm_pkg::CH_W'($urandom_range(0, 15)), num, den);
  endtask

  initial begin
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin : sink_loop
      int hold;
      hold = idle_cycles();
      if (hold > 0) begin
        res_if.ready = 1'b0;
        repeat (hold) @(negedge clk);
      end
      res_if.ready = 1'b1;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
  end

  initial begin : stimulus
    int tick_pct;
    steady             = 1'b0;
    rst_n              = 1'b0;
    req_if.valid       = 1'b0;
    req_if.opcode      = mbpwm_pkg::OP_SET;
    req_if.channel     = '0;
    req_if.numerator   = '0;
    req_if.denominator = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all channels still low; tick ignores its other fields
    send_request(mbpwm_pkg::OP_TICK, 4'hF, 8'hFF, 8'hFF);
    send_request(mbpwm_pkg::OP_SET, 4'd0, 8'hFF, 8'h00);   // zero denominator
    send_request(mbpwm_pkg::OP_SET, 4'd5, 8'h00, 8'h00);
    send_request(mbpwm_pkg::OP_SET, 4'd1, 8'hFF, 8'h01);   // quotient saturates
    send_request(mbpwm_pkg::OP_SET, 4'd2, 8'h01, 8'h01);   // exactly full period
    send_request(mbpwm_pkg::OP_SET, 4'd3, 8'h01, 8'h02);
    send_request(mbpwm_pkg::OP_SET, 4'd4, 8'h01, 8'hFF);   // truncates to zero
    send_request(mbpwm_pkg::OP_SET, 4'd7, 8'h03, 8'hFF);
    send_request(mbpwm_pkg::OP_SET, 4'd8, 8'hFF, 8'hFF);
    send_request(mbpwm_pkg::OP_SET, 4'd9, 8'hFE, 8'hFF);
    send_request(mbpwm_pkg::OP_SET, 4'd15, 8'h00, 8'hFF);
    send_request(mbpwm_pkg::OP_SET, 4'd14, 8'h80, 8'h81);
    for (int i = 0; i < 8; i++) send_request(mbpwm_pkg::OP_TICK, 4'h0, 8'h00, 8'h00);
    wait_for_results();

    for (int seg = 0; seg < RANDOM_REQUESTS / SEGMENT_LEN; seg++) begin
      steady   = ($urandom_range(0, 3) == 0);
      tick_pct = (seg % 3 == 1) ? 50 : 85;
      for (int n = 0; n < SEGMENT_LEN; n++) begin
        if ($urandom_range(0, 99) < tick_pct) begin
          send_request(mbpwm_pkg::OP_TICK, mbpwm_pkg::CH_W'($urandom_range(0, 15)),
                       mbpwm_pkg::NUM_W'($urandom_range(0, 255)),
                       mbpwm_pkg::NUM_W'($urandom_range(0, 255)));
        end else begin
          send_random_duty();
        end
      end
      if (seg == 0 || $urandom_range(0, 2) == 0) wait_for_results();
    end
    steady = 1'b0;

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (check_errors == 0) begin
      $display("multichannel_buffered_pwm_unit: match");
    end else begin
      $display("multichannel_buffered_pwm_unit: mismatch");
    end
    $finish;
  end

endmodule
